### design/duplicate_value_filter_core_defines.svh
// Assertion macros used by the duplicate value filter top level.
`ifndef DUPLICATE_VALUE_FILTER_CORE_DEFINES_SVH
`define DUPLICATE_VALUE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define DVF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too.
`define DVF_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/dvf_pkg.sv
// Types shared by the duplicate value filter front end, search engine and top level.
package dvf_pkg;

  localparam int FIELD_W = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               keep;
    logic               overflow;
    logic               last;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_xfer_t;

endpackage

### design/duplicate_value_filter_core.sv
// Top level of the duplicate value filter: front queue, table search and result port.
//
//   channel   direction  handshake        fields
//   input     in         push / full      item_value, end_of_list
//   result    out        empty / pop      out_value, keep, table_overflow, out_last
//
// An item goes from the idle state straight to the finish state when the table is
// empty, otherwise through the scan state, which reads table entries one by one, at
// most the current table fill, from the single read port of the seen-value memory.
// Reset clears the queues and the table fill count; no clearing pass is needed.
// A waiting result holds the search engine at its last step; the two-entry input
// queue keeps taking transactions meanwhile until it is full.
`include "duplicate_value_filter_core_defines.svh"

module duplicate_value_filter_core #(
  parameter int MAX_DISTINCT = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [dvf_pkg::FIELD_W-1:0]   item_value,
  input  logic                                 end_of_list,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [dvf_pkg::FIELD_W-1:0]   out_value,
  output logic                                 keep,
  output logic                                 table_overflow,
  output logic                                 out_last
);
  import dvf_pkg::*;

  item_t      in_item;
  item_xfer_t xfer;
  logic       back_ready;
  logic       res_valid;
  result_t    res;

  assign in_item.value = item_value;
  assign in_item.last  = end_of_list;

  dvf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .out_xfer (xfer),
    .out_ready(back_ready)
  );

  dvf_back #(
    .MAX_DISTINCT(MAX_DISTINCT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_xfer  (xfer),
    .in_ready (back_ready),
    .res_valid(res_valid),
    .res      (res),
    .res_pop  (pop && !empty)
  );

  assign empty          = !res_valid;
  assign out_value      = res.value;
  assign keep           = res.keep;
  assign table_overflow = res.overflow;
  assign out_last       = res.last;

  `DVF_ASSERT_IMPL(a_overflow_keeps, clk, rst, !empty, !table_overflow || keep, "overflow without keep")
  `DVF_ASSERT_NEXT(a_reset_clears, clk, rst, empty && !full, "queues not cleared by reset")

endmodule

### design/dvf_front.sv
// Front end: accepts input transactions into a two-entry queue for the search engine.
module dvf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  dvf_pkg::item_t     in_item,
  output dvf_pkg::item_xfer_t out_xfer,
  input  logic               out_ready
);
  import dvf_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full          = (count == 2'd2);
  assign do_push       = push && !full;
  assign do_pop        = out_xfer.valid && out_ready;
  assign out_xfer.valid = (count != 2'd0);
  assign out_xfer.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= in_item;
  end

endmodule

### design/dvf_back.sv
// Search engine: scans the seen-value table, records new values and holds the result.
module dvf_back #(
  parameter int MAX_DISTINCT = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  dvf_pkg::item_xfer_t in_xfer,
  output logic                in_ready,
  output logic                res_valid,
  output dvf_pkg::result_t    res,
  input  logic                res_pop
);
  import dvf_pkg::*;

  localparam int KEY_W = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int IDX_W = $clog2(MAX_DISTINCT);
  localparam int CNT_W = $clog2(MAX_DISTINCT + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t           state;
  item_t            cur;
  logic [KEY_W-1:0] key;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [CNT_W-1:0] count;
  logic [KEY_W-1:0] mem [MAX_DISTINCT];
  logic [KEY_W-1:0] mem_q;
  logic [IDX_W-1:0] rd_addr;
  logic             res_free;
  logic             has_room;
  logic             mem_we;
  logic             scan_end;

  assign in_ready = (state == S_IDLE);
  assign res_free = !res_valid || res_pop;
  assign has_room = (count < CNT_W'(MAX_DISTINCT));
  assign mem_we   = (state == S_FINISH) && res_free && !found && has_room;
  assign scan_end = ((CNT_W'(cmp_idx) + CNT_W'(1)) == count);

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = '0;
      S_SCAN:  rd_addr = cmp_idx + IDX_W'(1);
      default: rd_addr = cmp_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[count[IDX_W-1:0]] <= key;
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop && (state != S_FINISH)) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer.valid) begin
            cur     <= in_xfer.item;
            key     <= in_xfer.item.value[KEY_W-1:0];
            cmp_idx <= '0;
            found   <= 1'b0;
            state   <= (count == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (mem_q == key) begin
            found <= 1'b1;
            state <= S_FINISH;
          end else if (scan_end) begin
            state <= S_FINISH;
          end else begin
            cmp_idx <= cmp_idx + IDX_W'(1);
          end
        end
        S_FINISH: begin
          if (res_free) begin
            res_valid    <= 1'b1;
            res.value    <= cur.value;
            res.keep     <= !found;
            res.overflow <= !found && !has_room;
            res.last     <= cur.last;
            if (cur.last) count <= '0;
            else if (mem_we) count <= count + CNT_W'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
